### hdl/mkd_pkg.sv
// shared types, constants and the letter table for the morse key decoder
`timescale 1ns / 1ps

package mkd_pkg;

  localparam int MAX_ELEMENTS = 4;
  localparam int COUNT_WIDTH  = 16;
  localparam int CFG_WIDTH    = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int ELEM_CNT_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int ELEM_IDX_W   = $clog2(MAX_ELEMENTS);
  localparam int CMP_WIDTH    = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam int CHAR_W       = 7;
  localparam int LAMP_W       = 3;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_DOT_TIME      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_TIME     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_GAP_TIME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_GAP_TIME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP_TIME = 3'd4;

  localparam logic [CFG_WIDTH-1:0] DOT_TIME_RST      = 16'd2000;
  localparam logic [CFG_WIDTH-1:0] DASH_TIME_RST     = 16'd4000;
  localparam logic [CFG_WIDTH-1:0] ELEM_GAP_TIME_RST = 16'd8000;
  localparam logic [CFG_WIDTH-1:0] CHAR_GAP_TIME_RST = 16'd12000;
  localparam logic [CFG_WIDTH-1:0] WORD_GAP_TIME_RST = 16'd16000;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_DOT  = 2'd1;
  localparam logic [1:0] PEND_DASH = 2'd2;

  localparam logic [LAMP_W-1:0] LAMP_OFF    = 3'b000;
  localparam logic [LAMP_W-1:0] LAMP_DOT    = 3'b001;
  localparam logic [LAMP_W-1:0] LAMP_DASH   = 3'b010;
  localparam logic [LAMP_W-1:0] LAMP_STATUS = 3'b100;

  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'd0;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic [CFG_WIDTH-1:0] dot_time;
    logic [CFG_WIDTH-1:0] dash_time;
    logic [CFG_WIDTH-1:0] element_gap_time;
    logic [CFG_WIDTH-1:0] char_gap_time;
    logic [CFG_WIDTH-1:0] word_gap_time;
  } mkd_cfg_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0]  tick_count;
    logic                    counting;
    logic                    key_before;
    logic [1:0]              pending_element;
    logic [MAX_ELEMENTS-1:0] element_pattern;
    logic [ELEM_CNT_W-1:0]   element_count;
    logic                    pattern_overflow;
    logic                    word_gap_armed;
    logic                    text_started;
    logic [LAMP_W-1:0]       lamp_levels;
  } mkd_state_t;

  typedef struct packed {
    logic              char_valid;
    logic [CHAR_W-1:0] char_code;
    logic              code_unknown;
  } mkd_result_t;

  // pattern bit i is set when element i is a dash; zero means no letter
  function automatic logic [CHAR_W-1:0] decode_letter(
    input logic [MAX_ELEMENTS-1:0] pattern,
    input logic [ELEM_CNT_W-1:0]   len
  );
    logic [6:0]        key;
    logic [CHAR_W-1:0] letter;
    key    = {len[2:0], pattern[3:0]};
    letter = CHAR_NONE;
    if (len != '0 && len <= ELEM_CNT_W'(4)) begin
      case (key)
        {3'd2, 4'd2}:  letter = 7'("A");
        {3'd4, 4'd1}:  letter = 7'("B");
        {3'd4, 4'd5}:  letter = 7'("C");
        {3'd3, 4'd1}:  letter = 7'("D");
        {3'd1, 4'd0}:  letter = 7'("E");
        {3'd4, 4'd4}:  letter = 7'("F");
        {3'd3, 4'd3}:  letter = 7'("G");
        {3'd4, 4'd0}:  letter = 7'("H");
        {3'd2, 4'd0}:  letter = 7'("I");
        {3'd4, 4'd14}: letter = 7'("J");
        {3'd3, 4'd5}:  letter = 7'("K");
        {3'd4, 4'd2}:  letter = 7'("L");
        {3'd2, 4'd3}:  letter = 7'("M");
        {3'd2, 4'd1}:  letter = 7'("N");
        {3'd3, 4'd7}:  letter = 7'("O");
        {3'd4, 4'd6}:  letter = 7'("P");
        {3'd4, 4'd11}: letter = 7'("Q");
        {3'd3, 4'd2}:  letter = 7'("R");
        {3'd3, 4'd0}:  letter = 7'("S");
        {3'd1, 4'd1}:  letter = 7'("T");
        {3'd3, 4'd4}:  letter = 7'("U");
        {3'd4, 4'd8}:  letter = 7'("V");
        {3'd3, 4'd6}:  letter = 7'("W");
        {3'd4, 4'd9}:  letter = 7'("X");
        {3'd4, 4'd13}: letter = 7'("Y");
        {3'd4, 4'd3}:  letter = 7'("Z");
        default:       letter = CHAR_NONE;
      endcase
    end
    return letter;
  endfunction

endpackage

### hdl/morse_key_decoder.sv
// morse key decoder top level: config registers, decoder state and output register
`timescale 1ns / 1ps

// Morse key decoder. Each input request is one timer tick carrying the sampled
// key level (in_key_level, 1 = pressed). Every accepted tick gives exactly one
// output request: char_valid/char_code carry a decoded letter A to Z or a word
// space (32), code_unknown flags a pattern that is no letter or is too long,
// and the three lamp outputs show the lamp levels after that tick.
// Timing thresholds (dot, dash, element gap, character gap, word gap) are set
// through the cfg_ write port, indexes 0 to 4, in ticks after a key press;
// write them only while no request is in flight.
// The output request is registered and appears in the cycle after the tick is accepted.
// One tick per cycle while no stalled result is held, set by the single output register; the
// decoder state updates in the same cycle a tick is accepted.
// When the receiver raises out_stall, the result holds in the output register
// and in_stall follows, so no new tick is taken until the result is taken.
// Reset (rst_n low, synchronous) empties the output register, clears the
// decoder state with all lamps off, and loads the default thresholds
// 2000, 4000, 8000, 12000 and 16000.

module morse_key_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_key_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_char_valid,
  output logic [mkd_pkg::CHAR_W-1:0]        out_char_code,
  output logic                              out_code_unknown,
  output logic                              out_dot_lamp,
  output logic                              out_dash_lamp,
  output logic                              out_status_lamp,
  input  logic                              cfg_write_en,
  input  logic [mkd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mkd_pkg::CFG_WIDTH-1:0]     cfg_data
);
  import mkd_pkg::*;

  mkd_cfg_t          cfg_r;
  mkd_state_t        state_r;
  mkd_state_t        state_nxt;
  mkd_result_t       result;
  logic              out_valid_r;
  logic              char_valid_r;
  logic [CHAR_W-1:0] char_code_r;
  logic              code_unknown_r;
  logic [LAMP_W-1:0] lamps_r;
  logic              in_accept;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_time         <= DOT_TIME_RST;
      cfg_r.dash_time        <= DASH_TIME_RST;
      cfg_r.element_gap_time <= ELEM_GAP_TIME_RST;
      cfg_r.char_gap_time    <= CHAR_GAP_TIME_RST;
      cfg_r.word_gap_time    <= WORD_GAP_TIME_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_DOT_TIME:      cfg_r.dot_time         <= cfg_data;
        REG_DASH_TIME:     cfg_r.dash_time        <= cfg_data;
        REG_ELEM_GAP_TIME: cfg_r.element_gap_time <= cfg_data;
        REG_CHAR_GAP_TIME: cfg_r.char_gap_time    <= cfg_data;
        REG_WORD_GAP_TIME: cfg_r.word_gap_time    <= cfg_data;
        default: ;
      endcase
    end
  end

  mkd_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .key_level (in_key_level),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload only, loads with each accepted tick
  always_ff @(posedge clk) begin
    if (in_accept) begin
      char_valid_r   <= result.char_valid;
      char_code_r    <= result.char_code;
      code_unknown_r <= result.code_unknown;
      lamps_r        <= state_nxt.lamp_levels;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char_valid   = char_valid_r;
  assign out_char_code    = char_code_r;
  assign out_code_unknown = code_unknown_r;
  assign out_dot_lamp     = lamps_r[0];
  assign out_dash_lamp    = lamps_r[1];
  assign out_status_lamp  = lamps_r[2];

endmodule

### hdl/mkd_step.sv
// next-state and result logic for one key tick
`timescale 1ns / 1ps

module mkd_step (
  input  mkd_pkg::mkd_cfg_t    cfg,
  input  mkd_pkg::mkd_state_t  state,
  input  logic                 key_level,
  output mkd_pkg::mkd_state_t  state_nxt,
  output mkd_pkg::mkd_result_t result
);
  import mkd_pkg::*;

  function automatic logic thr_hit(
    input logic [COUNT_WIDTH-1:0] t,
    input logic [CFG_WIDTH-1:0]   thr
  );
    return CMP_WIDTH'(t) == CMP_WIDTH'(thr);
  endfunction

  always_comb begin
    mkd_state_t             nx;
    mkd_result_t            res;
    logic                   rise;
    logic                   armed_before;
    logic [COUNT_WIDTH-1:0] t;
    logic [CHAR_W-1:0]      letter;

    nx           = state;
    res          = '{char_valid: 1'b0, char_code: CHAR_NONE, code_unknown: 1'b0};
    rise         = key_level && !state.key_before;
    armed_before = state.word_gap_armed;
    t            = state.tick_count + COUNT_WIDTH'(1);
    letter       = CHAR_NONE;

    nx.key_before = key_level;
    if (rise) begin
      nx.tick_count     = '0;
      nx.counting       = 1'b1;
      nx.word_gap_armed = 1'b0;
      nx.lamp_levels    = LAMP_OFF;
    end else if (state.counting && state.tick_count != COUNT_MAX) begin
      nx.tick_count = t;
      // events of one tick apply in threshold order, the last one wins the lamps
      if (thr_hit(t, cfg.dot_time) && key_level) begin
        nx.pending_element = PEND_DOT;
        nx.lamp_levels     = LAMP_DOT;
      end
      if (thr_hit(t, cfg.dash_time) && key_level) begin
        nx.pending_element = PEND_DASH;
        nx.lamp_levels     = LAMP_DASH;
      end
      if (thr_hit(t, cfg.element_gap_time)) begin
        if (nx.pending_element != PEND_NONE) begin
          if (nx.element_count < ELEM_CNT_W'(MAX_ELEMENTS)) begin
            if (nx.pending_element == PEND_DASH) begin
              nx.element_pattern[nx.element_count[ELEM_IDX_W-1:0]] = 1'b1;
            end
            nx.element_count = nx.element_count + ELEM_CNT_W'(1);
          end else begin
            nx.pattern_overflow = 1'b1;
          end
        end
        nx.pending_element = PEND_NONE;
        nx.lamp_levels     = LAMP_STATUS;
      end
      if (thr_hit(t, cfg.char_gap_time)) begin
        nx.lamp_levels = LAMP_DOT | LAMP_DASH;
        if (nx.element_count != '0 || nx.pattern_overflow) begin
          letter = nx.pattern_overflow ? CHAR_NONE
                                       : decode_letter(nx.element_pattern, nx.element_count);
          if (letter != CHAR_NONE) begin
            res.char_valid  = 1'b1;
            res.char_code   = letter;
            nx.text_started = 1'b1;
          end else begin
            res.code_unknown = 1'b1;
          end
          nx.element_pattern  = '0;
          nx.element_count    = '0;
          nx.pattern_overflow = 1'b0;
        end
        nx.word_gap_armed = 1'b1;
      end
      // word gap only counts once a character gap went by on an earlier tick
      if (thr_hit(t, cfg.word_gap_time) && armed_before) begin
        nx.lamp_levels = LAMP_DOT | LAMP_DASH | LAMP_STATUS;
        if (nx.text_started) begin
          res.char_valid = 1'b1;
          res.char_code  = CHAR_SPACE;
        end
        nx.counting       = 1'b0;
        nx.word_gap_armed = 1'b0;
        nx.tick_count     = '0;
      end
    end

    state_nxt = nx;
    result    = res;
  end

endmodule

### hdl/mkd_checker.sv
// port-level checks for the morse key decoder, bound to the top level
`timescale 1ns / 1ps

module mkd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_char_valid,
  input logic [mkd_pkg::CHAR_W-1:0]    out_char_code,
  input logic                          out_code_unknown,
  input logic                          out_dot_lamp,
  input logic                          out_dash_lamp,
  input logic                          out_status_lamp
);
  import mkd_pkg::*;

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output request present after reset");

  // a stalled request holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_valid) &&
      $stable(out_char_code) && $stable(out_code_unknown) && $stable(out_dot_lamp) &&
      $stable(out_dash_lamp) && $stable(out_status_lamp))
    else $error("stalled output request changed");

  // a character and an unknown flag never come together, no code without a character
  a_char_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_char_valid && out_code_unknown) &&
      (out_char_valid || out_char_code == CHAR_NONE))
    else $error("inconsistent character flags");

  // emitted code is a space or an upper-case letter
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_valid |-> out_char_code == CHAR_SPACE ||
      (out_char_code >= 7'("A") && out_char_code <= 7'("Z")))
    else $error("emitted code outside letters and space");

  // status lamp only alone or with both other lamps
  a_lamp_combo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_lamp |-> (out_dot_lamp == out_dash_lamp))
    else $error("illegal lamp combination");

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_char_valid   (out_char_valid),
  .out_char_code    (out_char_code),
  .out_code_unknown (out_code_unknown),
  .out_dot_lamp     (out_dot_lamp),
  .out_dash_lamp    (out_dash_lamp),
  .out_status_lamp  (out_status_lamp)
);
